/* hdl/vpv_pkg.sv */
// Shared types and constants of the vertex projection and viewport pipeline.
package vpv_pkg;

  localparam int COORD_FRAC_BITS = 16;
  localparam int IN_W            = 32;
  localparam int ENT_W           = 16;
  localparam int CFG_W           = 64;
  localparam int CFG_IDX_W       = 3;
  localparam int XF_PROD_W       = ENT_W + IN_W;
  localparam int CLIP_W          = 50;
  localparam int MAG_W           = CLIP_W - 1;
  localparam int Q_W             = 44;
  localparam int INT_Q_W         = Q_W - COORD_FRAC_BITS;
  localparam int NP_W            = Q_W + 2;
  localparam int DIFF_W          = ENT_W + 1;
  localparam int MAP_PROD_W      = DIFF_W + NP_W;
  localparam int SUM_W           = 64;
  localparam int OUT_W           = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_COL0     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL1     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COL2     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COL3     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEWPORT = 3'd4;

  localparam logic signed [NP_W-1:0] NDC_ONE = NP_W'(1) << COORD_FRAC_BITS;

  typedef logic signed [CLIP_W-1:0] clip_t;
  typedef logic signed [Q_W:0]      ndc_t;

  typedef struct packed {
    logic valid;
    logic winv;
  } ctl_t;

endpackage

/* hdl/vpv_xform.sv */
// Matrix transform stages: point times 4x4 matrix, giving clip coordinates.
module vpv_xform (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                en,
  input  logic                                valid_in,
  input  logic signed [vpv_pkg::IN_W-1:0]     pt_in [3],
  input  logic [vpv_pkg::CFG_W-1:0]           mat_in [4],
  output logic                                valid_out,
  output vpv_pkg::clip_t                      clip_out [4]
);
  import vpv_pkg::*;

  logic signed [XF_PROD_W-1:0] prod_r [4][3];
  clip_t                       trans_r [4];
  clip_t                       clip_r [4];
  logic                        valid1_r;
  logic                        valid2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r <= 1'b0;
      valid2_r <= 1'b0;
    end else if (en) begin
      valid1_r <= valid_in;
      valid2_r <= valid1_r;
    end
  end

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic [ENT_W-1:0] tr;
    assign tr = mat_in[3][ENT_W*r +: ENT_W];
    for (genvar c = 0; c < 3; c++) begin : g_col
      always_ff @(posedge clk) begin
        if (en) begin
          prod_r[r][c] <= $signed(mat_in[c][ENT_W*r +: ENT_W]) * pt_in[c];
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        trans_r[r] <= {{(CLIP_W-ENT_W-COORD_FRAC_BITS){tr[ENT_W-1]}}, tr,
                       {COORD_FRAC_BITS{1'b0}}};
        clip_r[r]  <= CLIP_W'(prod_r[r][0]) + CLIP_W'(prod_r[r][1])
                    + CLIP_W'(prod_r[r][2]) + trans_r[r];
      end
    end
    assign clip_out[r] = clip_r[r];
  end

  assign valid_out = valid2_r;

endmodule

/* hdl/vpv_div.sv */
// Pipelined restoring divider: one quotient bit per stage for x, y and z over w.
module vpv_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              valid_in,
  input  vpv_pkg::clip_t    clip_in [4],
  output vpv_pkg::ctl_t     ctl_out,
  output vpv_pkg::ndc_t     ndc_out [3]
);
  import vpv_pkg::*;

  localparam int STEPS  = Q_W;
  localparam int STAGES = STEPS + 3;

  ctl_t  ctl_r [STAGES];
  clip_t w_mag;

  assign w_mag = clip_in[3][CLIP_W-1] ? -clip_in[3] : clip_in[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < STAGES; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= '{valid: valid_in, winv: (clip_in[3] == '0)};
      for (int i = 1; i < STAGES; i++) begin
        ctl_r[i] <= ctl_r[i-1];
      end
    end
  end

  assign ctl_out = ctl_r[STAGES-1];

  for (genvar l = 0; l < 3; l++) begin : g_lane
    clip_t            c_mag;
    logic [MAG_W-1:0] a0_r;
    logic [MAG_W-1:0] b0_r;
    logic             neg0_r;
    logic [MAG_W-1:0] rem_r [STEPS+1];
    logic [MAG_W-1:0] b_r   [STEPS+1];
    logic [Q_W-1:0]   sq_r  [STEPS+1];
    logic             neg_r [STEPS+1];
    logic             ovf_r [STEPS+1];
    ndc_t             ndc_r;
    logic [Q_W-1:0]   q_fin;

    assign c_mag = clip_in[l][CLIP_W-1] ? -clip_in[l] : clip_in[l];

    always_ff @(posedge clk) begin
      if (en) begin
        a0_r   <= c_mag[MAG_W-1:0];
        b0_r   <= w_mag[MAG_W-1:0];
        neg0_r <= clip_in[l][CLIP_W-1] ^ clip_in[3][CLIP_W-1];
        // The integer part must stay below 2^28, otherwise the result clamps.
        rem_r[0] <= {{INT_Q_W{1'b0}}, a0_r[MAG_W-1:INT_Q_W]};
        sq_r[0]  <= {a0_r[INT_Q_W-1:0], {COORD_FRAC_BITS{1'b0}}};
        b_r[0]   <= b0_r;
        neg_r[0] <= neg0_r;
        ovf_r[0] <= ({{INT_Q_W{1'b0}}, a0_r[MAG_W-1:INT_Q_W]} >= b0_r);
      end
    end

    for (genvar j = 1; j <= STEPS; j++) begin : g_step
      logic [MAG_W:0] t;
      logic [MAG_W:0] diff;
      logic           ge;
      assign t    = {rem_r[j-1], sq_r[j-1][Q_W-1]};
      assign diff = t - {1'b0, b_r[j-1]};
      assign ge   = (t >= {1'b0, b_r[j-1]});
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[j] <= ge ? diff[MAG_W-1:0] : t[MAG_W-1:0];
          sq_r[j]  <= {sq_r[j-1][Q_W-2:0], ge};
          b_r[j]   <= b_r[j-1];
          neg_r[j] <= neg_r[j-1];
          ovf_r[j] <= ovf_r[j-1];
        end
      end
    end

    assign q_fin = ovf_r[STEPS] ? '1 : sq_r[STEPS];

    always_ff @(posedge clk) begin
      if (en) begin
        ndc_r <= neg_r[STEPS] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
      end
    end

    assign ndc_out[l] = ndc_r;
  end

endmodule

/* hdl/vpv_map.sv */
// Viewport and depth mapping stages with saturation to the 32-bit range.
module vpv_map (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  vpv_pkg::ctl_t                 ctl_in,
  input  vpv_pkg::ndc_t                 ndc_in [3],
  input  logic [vpv_pkg::CFG_W-1:0]     vport_in,
  output vpv_pkg::ctl_t                 ctl_out,
  output logic [vpv_pkg::OUT_W-1:0]     res_out [3]
);
  import vpv_pkg::*;

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = -SUM_W'(64'sd2147483648);

  function automatic logic [OUT_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] s;
    s = v;
    if (s > SAT_MAX) s = SAT_MAX;
    if (s < SAT_MIN) s = SAT_MIN;
    return s[OUT_W-1:0];
  endfunction

  ctl_t ctl_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        ctl_r[i] <= '0;
      end
    end else if (en) begin
      ctl_r[0] <= ctl_in;
      ctl_r[1] <= ctl_r[0];
      ctl_r[2] <= ctl_r[1];
    end
  end

  assign ctl_out = ctl_r[2];

  // Lanes 0 and 1 map into the viewport; lane 0 uses left/right, lane 1 bottom/top.
  for (genvar l = 0; l < 2; l++) begin : g_axis
    logic [ENT_W-1:0]               lo;
    logic [ENT_W-1:0]               hi;
    logic signed [DIFF_W-1:0]       d_r;
    logic signed [NP_W-1:0]         np_r;
    logic signed [ENT_W-1:0]        lo1_r;
    logic signed [ENT_W-1:0]        lo2_r;
    logic signed [MAP_PROD_W-1:0]   prod_r;
    logic signed [SUM_W-1:0]        sum;
    logic [OUT_W-1:0]               res_r;

    assign lo  = vport_in[ENT_W*l +: ENT_W];
    assign hi  = vport_in[ENT_W*(l+2) +: ENT_W];
    assign sum = (SUM_W'(lo2_r) <<< COORD_FRAC_BITS) + SUM_W'(prod_r >>> 1);

    always_ff @(posedge clk) begin
      if (en) begin
        d_r    <= $signed({hi[ENT_W-1], hi}) - $signed({lo[ENT_W-1], lo});
        np_r   <= NP_W'(ndc_in[l]) + NDC_ONE;
        lo1_r  <= $signed(lo);
        prod_r <= d_r * np_r;
        lo2_r  <= lo1_r;
        res_r  <= ctl_r[1].winv ? '0 : sat32(sum);
      end
    end

    assign res_out[l] = res_r;
  end

  logic signed [NP_W-1:0] dn_r;
  logic signed [NP_W-1:0] dh_r;
  logic [OUT_W-1:0]       dres_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dn_r   <= NP_W'(ndc_in[2]) + NDC_ONE;
      dh_r   <= dn_r >>> 1;
      dres_r <= ctl_r[1].winv ? '0 : sat32(SUM_W'(dh_r));
    end
  end

  assign res_out[2] = dres_r;

endmodule

/* hdl/vertex_project_viewport.sv */
// Top level of the vertex projection and viewport transform pipeline.
// Each transfer carries one point (x, y, z in signed Q16.16); it is multiplied
// by the configured column-major 4x4 matrix (Q4.12 entries), divided by the
// homogeneous w and mapped into the viewport, with depth mapped to zero..one.
// The pipeline takes one point every cycle unless the result side stalls; each
// result passes through the matrix multiply and sum, then the divider, which
// resolves one quotient bit per stage, then the viewport mapping. When the
// result side stalls, the whole pipeline holds. A zero w gives zero outputs
// with the w_invalid flag set. The user must write the registers only while
// no point is in flight; the block leaves this to the user.
module vertex_project_viewport (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [vpv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [vpv_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [95:0]                         in_tdata,   // point_x, point_y, point_z
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [95:0]                         out_tdata,  // screen_x, screen_y, screen_depth
  output logic                                out_tuser   // w_invalid
);
  import vpv_pkg::*;

  logic [CFG_W-1:0]       mat_r [4];
  logic [CFG_W-1:0]       vport_r;
  logic                   en;
  logic signed [IN_W-1:0] pt [3];
  logic                   xf_valid;
  clip_t                  clip [4];
  ctl_t                   div_ctl;
  ndc_t                   ndc [3];
  ctl_t                   map_ctl;
  logic [OUT_W-1:0]       res [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) begin
        mat_r[i] <= '0;
      end
      vport_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_COL0:     mat_r[0] <= cfg_wdata;
        CFG_COL1:     mat_r[1] <= cfg_wdata;
        CFG_COL2:     mat_r[2] <= cfg_wdata;
        CFG_COL3:     mat_r[3] <= cfg_wdata;
        CFG_VIEWPORT: vport_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // The output stage doubles as the result register; everything moves together.
  assign en        = !map_ctl.valid || out_tready;
  assign in_tready = en;

  assign pt[0] = in_tdata[31:0];
  assign pt[1] = in_tdata[63:32];
  assign pt[2] = in_tdata[95:64];

  vpv_xform u_xform (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .valid_in  (in_tvalid),
    .pt_in     (pt),
    .mat_in    (mat_r),
    .valid_out (xf_valid),
    .clip_out  (clip)
  );

  vpv_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .valid_in (xf_valid),
    .clip_in  (clip),
    .ctl_out  (div_ctl),
    .ndc_out  (ndc)
  );

  vpv_map u_map (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .ctl_in   (div_ctl),
    .ndc_in   (ndc),
    .vport_in (vport_r),
    .ctl_out  (map_ctl),
    .res_out  (res)
  );

  assign out_tvalid = map_ctl.valid;
  assign out_tdata  = {res[2], res[1], res[0]};
  assign out_tuser  = map_ctl.winv;

endmodule
